FILE: design/rpid_pkg.sv
`default_nettype none

package rpid_pkg;

    // Default channel count
    localparam int NUM_INPUTS_DEF = 8;

    // Field widths
    localparam int TIME_W  = 16;
    localparam int PORT_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Failsafe channels and the full mark set
    localparam int          FS_CHANNELS = 4;
    localparam logic [3:0]  FS_ALL      = 4'hF;

    // Item function codes
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_PPM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FS_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP  = 3'd4;

    // Register reset values
    localparam logic              MODE_PPM_RST  = 1'b1;
    localparam logic [TIME_W-1:0] PULSE_MIN_RST = 16'd750;
    localparam logic [TIME_W-1:0] PULSE_MAX_RST = 16'd2250;
    localparam logic [TIME_W-1:0] FS_THRESH_RST = 16'd985;
    localparam logic [TIME_W-1:0] SYNC_GAP_RST  = 16'd2700;

endpackage

`default_nettype wire

FILE: design/rpid_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module rpid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire                        aclk,
    input  wire                        wr_en,
    input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire  [WIDTH-1:0]           wr_data,
    input  wire                        rd_en,
    input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // Hold the read data while no read is issued
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/rc_pulse_input_decoder.sv
`default_nettype none

// RC receiver pulse decoder. Each input item is either a captured edge
// timestamp or a read of a stored channel width; each gives exactly one
// result item. In PPM mode the wrapping interval to the previous edge either
// restarts channel numbering (above the sync gap) or, when strictly inside
// the pulse window, is stored for the current channel. In PWM mode each port
// alternates rising and falling edges and stores fall minus rise. Good pulses
// on channels 0 to 3 set marks; a full set clears them and raises a failsafe
// credit. The block takes one item per clock while the receiver keeps up.
// An accepted item reads the width and rise-time memories, then updates
// state, writes back and loads the output register. A write is forwarded
// to the item right behind it, so back-to-back edges on one port decode
// correctly. Width entries start at zero through per-entry valid bits, so
// no clearing pass runs after reset. The user must write configuration
// through the plain write port only while the block idles (not enforced).
module rc_pulse_input_decoder #(
    parameter int NUM_INPUTS = rpid_pkg::NUM_INPUTS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,

    // Configuration write port
    input  wire                              cfg_wr_en,
    input  wire  [rpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [rpid_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // Input items
    input  wire          s_tvalid,
    output logic         s_tready,
    // tdata: port[2:0], capture_time[18:3], read_channel[21:19], zero pad
    input  wire  [23:0]  s_tdata,
    // tuser: func
    input  wire          s_tuser,

    // Result items
    output logic         m_tvalid,
    input  wire          m_tready,
    // tdata: read_width[15:0], width_stored[16], stored_channel[19:17],
    //        stored_width[35:20], frame_sync[36], failsafe_credit[37], zero pad
    output logic [39:0]  m_tdata
);

    localparam int TW     = rpid_pkg::TIME_W;
    localparam int AW     = $clog2(NUM_INPUTS);
    localparam int CNT_W  = $clog2(NUM_INPUTS + 1);
    localparam int EXT_W  = (CNT_W > rpid_pkg::PORT_W) ? CNT_W : rpid_pkg::PORT_W;
    localparam logic [EXT_W-1:0] NUM_EXT = EXT_W'(NUM_INPUTS);
    localparam logic [EXT_W-1:0] FS_EXT  = EXT_W'(rpid_pkg::FS_CHANNELS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          mode_ppm_reg;
    logic [TW-1:0] pulse_min_reg;
    logic [TW-1:0] pulse_max_reg;
    logic [TW-1:0] fs_thresh_reg;
    logic [TW-1:0] sync_gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_ppm_reg  <= rpid_pkg::MODE_PPM_RST;
            pulse_min_reg <= rpid_pkg::PULSE_MIN_RST;
            pulse_max_reg <= rpid_pkg::PULSE_MAX_RST;
            fs_thresh_reg <= rpid_pkg::FS_THRESH_RST;
            sync_gap_reg  <= rpid_pkg::SYNC_GAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rpid_pkg::REG_MODE_PPM:  mode_ppm_reg  <= cfg_wdata[0];
                rpid_pkg::REG_PULSE_MIN: pulse_min_reg <= cfg_wdata;
                rpid_pkg::REG_PULSE_MAX: pulse_max_reg <= cfg_wdata;
                rpid_pkg::REG_FS_THRESH: fs_thresh_reg <= cfg_wdata;
                rpid_pkg::REG_SYNC_GAP:  sync_gap_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept and issue memory reads
    // ------------------------------------------------------------------
    logic          in_func;
    logic [2:0]    in_port;
    logic [TW-1:0] in_time;
    logic [2:0]    in_rch;
    logic          s_accept;

    assign in_func = s_tuser;
    assign in_port = s_tdata[2:0];
    assign in_time = s_tdata[18:3];
    assign in_rch  = s_tdata[21:19];

    logic [EXT_W-1:0] in_port_ext;
    logic [EXT_W-1:0] in_rch_ext;
    assign in_port_ext = EXT_W'(in_port);
    assign in_rch_ext  = EXT_W'(in_rch);

    logic          s1_valid_reg;
    logic          s1_func_reg;
    logic [2:0]    s1_port_reg;
    logic [TW-1:0] s1_time_reg;
    logic [2:0]    s1_rch_reg;
    logic          s1_fire;

    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_func_reg <= in_func;
            s1_port_reg <= in_port;
            s1_time_reg <= in_time;
            s1_rch_reg  <= in_rch;
        end
    end

    // ------------------------------------------------------------------
    // Memories: stored widths and rise times
    // ------------------------------------------------------------------
    logic          wt_we;
    logic [AW-1:0] wt_waddr;
    logic [TW-1:0] wt_wdata;
    logic [TW-1:0] wt_q;
    logic          rt_we;
    logic [AW-1:0] rt_waddr;
    logic [TW-1:0] rt_q;

    rpid_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_INPUTS)
    ) u_width_ram (
        .aclk    (aclk),
        .wr_en   (wt_we),
        .wr_addr (wt_waddr),
        .wr_data (wt_wdata),
        .rd_en   (s_accept),
        .rd_addr (in_rch_ext[AW-1:0]),
        .rd_data (wt_q)
    );

    rpid_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_INPUTS)
    ) u_rise_ram (
        .aclk    (aclk),
        .wr_en   (rt_we),
        .wr_addr (rt_waddr),
        .wr_data (s1_time_reg),
        .rd_en   (s_accept),
        .rd_addr (in_port_ext[AW-1:0]),
        .rd_data (rt_q)
    );

    // Latest write to each memory; covers a read issued on the same edge
    logic          wt_fwd_valid_reg;
    logic [AW-1:0] wt_fwd_addr_reg;
    logic [TW-1:0] wt_fwd_data_reg;
    logic          rt_fwd_valid_reg;
    logic [AW-1:0] rt_fwd_addr_reg;
    logic [TW-1:0] rt_fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_fwd_valid_reg <= 1'b0;
            rt_fwd_valid_reg <= 1'b0;
        end else begin
            if (wt_we) begin
                wt_fwd_valid_reg <= 1'b1;
            end
            if (rt_we) begin
                rt_fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_fwd_addr_reg <= wt_waddr;
            wt_fwd_data_reg <= wt_wdata;
        end
        if (rt_we) begin
            rt_fwd_addr_reg <= rt_waddr;
            rt_fwd_data_reg <= s1_time_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode, update state, write back
    // ------------------------------------------------------------------
    logic [TW-1:0]     last_edge_reg, last_edge_next;
    logic [CNT_W-1:0]  frame_ch_reg, frame_ch_next;
    logic [NUM_INPUTS-1:0] phase_reg, phase_next;
    logic [NUM_INPUTS-1:0] wt_valid_reg, wt_valid_next;
    logic [3:0]        marks_reg, marks_next;

    logic [EXT_W-1:0]  s1_port_ext;
    logic [EXT_W-1:0]  s1_rch_ext;
    logic [EXT_W-1:0]  frame_ch_ext;
    logic [AW-1:0]     s1_port_idx;
    logic [AW-1:0]     s1_rch_idx;
    logic [TW-1:0]     wt_rd;
    logic [TW-1:0]     rise_rd;
    logic [TW-1:0]     ppm_diff;
    logic [TW-1:0]     pwm_width;

    assign s1_port_ext  = EXT_W'(s1_port_reg);
    assign s1_rch_ext   = EXT_W'(s1_rch_reg);
    assign frame_ch_ext = EXT_W'(frame_ch_reg);
    assign s1_port_idx  = s1_port_ext[AW-1:0];
    assign s1_rch_idx   = s1_rch_ext[AW-1:0];

    assign wt_rd   = (wt_fwd_valid_reg && wt_fwd_addr_reg == s1_rch_idx) ?
                     wt_fwd_data_reg : wt_q;
    assign rise_rd = (rt_fwd_valid_reg && rt_fwd_addr_reg == s1_port_idx) ?
                     rt_fwd_data_reg : rt_q;

    assign ppm_diff  = s1_time_reg - last_edge_reg;
    assign pwm_width = s1_time_reg - rise_rd;

    logic             st_en;
    logic [EXT_W-1:0] st_ch;
    logic [TW-1:0]    st_w;
    logic             rt_wr;
    logic [TW-1:0]    r_width;
    logic             r_sync;
    logic             r_credit;

    // Decode the item and pick what to store
    always_comb begin
        st_en          = 1'b0;
        st_ch          = '0;
        st_w           = '0;
        rt_wr          = 1'b0;
        r_width        = '0;
        r_sync         = 1'b0;
        last_edge_next = last_edge_reg;
        frame_ch_next  = frame_ch_reg;
        phase_next     = phase_reg;
        if (s1_func_reg == rpid_pkg::FUNC_READ) begin
            if (s1_rch_ext < NUM_EXT && wt_valid_reg[s1_rch_idx]) begin
                r_width = wt_rd;
            end
        end else if (mode_ppm_reg) begin
            last_edge_next = s1_time_reg;
            if (ppm_diff > sync_gap_reg) begin
                frame_ch_next = '0;
                r_sync        = 1'b1;
            end else if (frame_ch_ext < NUM_EXT) begin
                if (ppm_diff > pulse_min_reg && ppm_diff < pulse_max_reg) begin
                    st_en = 1'b1;
                    st_ch = frame_ch_ext;
                    st_w  = ppm_diff;
                end
                frame_ch_next = frame_ch_reg + 1'b1;
            end
        end else if (s1_port_ext < NUM_EXT) begin
            if (!phase_reg[s1_port_idx]) begin
                rt_wr                   = 1'b1;
                phase_next[s1_port_idx] = 1'b1;
            end else begin
                if (pwm_width > pulse_min_reg && pwm_width < pulse_max_reg) begin
                    st_en = 1'b1;
                    st_ch = s1_port_ext;
                    st_w  = pwm_width;
                end
                phase_next[s1_port_idx] = 1'b0;
            end
        end
    end

    // Good marks and failsafe credit
    always_comb begin
        marks_next    = marks_reg;
        r_credit      = 1'b0;
        wt_valid_next = wt_valid_reg;
        if (st_en) begin
            wt_valid_next[st_ch[AW-1:0]] = 1'b1;
            if (st_ch < FS_EXT && st_w > fs_thresh_reg) begin
                marks_next = marks_reg | (4'b0001 << st_ch[1:0]);
            end
            if (marks_next == rpid_pkg::FS_ALL) begin
                marks_next = '0;
                r_credit   = 1'b1;
            end
        end
    end

    assign wt_we    = s1_fire && st_en;
    assign wt_waddr = st_ch[AW-1:0];
    assign wt_wdata = st_w;
    assign rt_we    = s1_fire && rt_wr;
    assign rt_waddr = s1_port_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_reg <= '0;
            frame_ch_reg  <= '0;
            phase_reg     <= '0;
            wt_valid_reg  <= '0;
            marks_reg     <= '0;
        end else if (s1_fire) begin
            last_edge_reg <= last_edge_next;
            frame_ch_reg  <= frame_ch_next;
            phase_reg     <= phase_next;
            wt_valid_reg  <= wt_valid_next;
            marks_reg     <= marks_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // Pack the result item; stored fields read zero unless a width was stored
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= {2'b00, r_credit, r_sync, st_w, st_ch[2:0], st_en, r_width};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = rpid_pkg::NUM_INPUTS_DEF;
    localparam int TW          = rpid_pkg::TIME_W;
    localparam int PW          = rpid_pkg::PORT_W;
    localparam int IW          = rpid_pkg::CFG_IDX_W;
    localparam int DW          = rpid_pkg::CFG_DATA_W;
    localparam int QUIET_LIMIT = 4000;  // cycles without any handshake
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int SETTLE      = 20;    // tail after the last result

    // One input item, as the block sees it
    typedef struct packed {
        logic          func;
        logic [PW-1:0] port;
        logic [TW-1:0] capture_time;
        logic [2:0]    read_channel;
    } pulse_item_t;

    // One result item; the first member sits in the top bits of m_tdata[37:0]
    typedef struct packed {
        logic          failsafe_credit;
        logic          frame_sync;
        logic [TW-1:0] stored_width;
        logic [2:0]    stored_channel;
        logic          width_stored;
        logic [TW-1:0] read_width;
    } decode_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [23:0]   s_tdata   = '0;  // port, capture_time, read_channel, pad
    logic          s_tuser   = 1'b0; // func
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [39:0]   m_tdata;         // read_width, width_stored, stored_channel,
                                    // stored_width, frame_sync, failsafe_credit, pad

    always #5 aclk = ~aclk;

    rc_pulse_input_decoder #(
        .NUM_INPUTS(NUM_CH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Shadow configuration, kept in step with every register write
    // ------------------------------------------------------------------
    logic          cfg_ppm    = rpid_pkg::MODE_PPM_RST;
    logic [TW-1:0] cfg_min    = rpid_pkg::PULSE_MIN_RST;
    logic [TW-1:0] cfg_max    = rpid_pkg::PULSE_MAX_RST;
    logic [TW-1:0] cfg_thresh = rpid_pkg::FS_THRESH_RST;
    logic [TW-1:0] cfg_gap    = rpid_pkg::SYNC_GAP_RST;

    // Decoder shadow state, at its reset values
    logic [TW-1:0] prev_capture = '0;
    logic [3:0]    ppm_channel  = '0;
    bit            awaiting_fall [NUM_CH];
    logic [TW-1:0] rise_stamp [NUM_CH] = '{default: '0};
    logic [TW-1:0] width_mem  [NUM_CH] = '{default: '0};
    logic [3:0]    good_mask    = '0;

    // Queues between the stimulus, the driver and the monitor
    pulse_item_t    capture_items[$];
    decode_result_t decoded_results[$];

    // Idling controls, set per phase by the stimulus process
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Stimulus-side view of the timer and of each port's edge phase
    logic [TW-1:0] gen_clock = '0;
    bit            gen_high [NUM_CH];
    logic [TW-1:0] gen_rise [NUM_CH] = '{default: '0};
    int unsigned   frame_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    bit          hold_request = 1'b0;
    bit          hold_taken   = 1'b0;
    int unsigned hold_left    = 0;

    // ------------------------------------------------------------------
    // Decode one accepted item and advance the shadow state
    // ------------------------------------------------------------------
    function automatic decode_result_t decode_item(pulse_item_t it);
        decode_result_t r;
        logic [TW-1:0] span;
        logic [2:0]    ch;
        bit hit;
        r    = '0;
        span = '0;
        ch   = '0;
        hit  = 1'b0;
        if (it.func == rpid_pkg::FUNC_READ) begin
            if (it.read_channel < NUM_CH)
                r.read_width = width_mem[it.read_channel];
        end else if (cfg_ppm) begin
            span = it.capture_time - prev_capture;
            prev_capture = it.capture_time;
            if (span > cfg_gap) begin
                // sync gap: restart numbering, store nothing
                ppm_channel  = '0;
                r.frame_sync = 1'b1;
            end else begin
                if (span > cfg_min && span < cfg_max && ppm_channel < NUM_CH) begin
                    hit = 1'b1;
                    ch  = ppm_channel[2:0];
                end
                // saturate rather than wrap
                if (ppm_channel < NUM_CH)
                    ppm_channel = ppm_channel + 4'd1;
            end
        end else if (it.port < NUM_CH) begin
            if (!awaiting_fall[it.port]) begin
                rise_stamp[it.port]    = it.capture_time;
                awaiting_fall[it.port] = 1'b1;
            end else begin
                span = it.capture_time - rise_stamp[it.port];
                if (span > cfg_min && span < cfg_max) begin
                    hit = 1'b1;
                    ch  = it.port;
                end
                awaiting_fall[it.port] = 1'b0;
            end
        end
        if (hit) begin
            width_mem[ch] = span;
            if (ch < rpid_pkg::FS_CHANNELS && span > cfg_thresh)
                good_mask[ch[1:0]] = 1'b1;
            if (good_mask == rpid_pkg::FS_ALL) begin
                good_mask         = '0;
                r.failsafe_credit = 1'b1;
            end
            r.width_stored   = 1'b1;
            r.stored_channel = ch;
            r.stored_width   = span;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [TW-1:0] want, logic [TW-1:0] seen);
        if (want !== seen) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present items from the queue, decode each one on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        pulse_item_t offer;
        if (s_tvalid && s_tready)
            decoded_results.push_back(decode_item(offer));
        // advance only once the current item has gone, otherwise hold it
        if (!s_tvalid || s_tready) begin
            if (aresetn && capture_items.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                offer    = capture_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, offer.read_channel, offer.capture_time, offer.port};
                s_tuser  <= offer.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result with the oldest decode, then pick tready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        decode_result_t want;
        decode_result_t seen;
        if (m_tvalid && m_tready) begin
            seen = decode_result_t'(m_tdata[37:0]);
            if (decoded_results.size() == 0) begin
                $display("%0t ns: result with none outstanding, expected none, got %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = decoded_results.pop_front();
                check_field("read_width", want.read_width, seen.read_width);
                check_field("width_stored", TW'(want.width_stored),
                            TW'(seen.width_stored));
                check_field("stored_channel", TW'(want.stored_channel),
                            TW'(seen.stored_channel));
                check_field("stored_width", want.stored_width, seen.stored_width);
                check_field("frame_sync", TW'(want.frame_sync), TW'(seen.frame_sync));
                check_field("failsafe_credit", TW'(want.failsafe_credit),
                            TW'(seen.failsafe_credit));
            end
        end
        m_tready <= aresetn && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end

    // Long receiver hold-off, armed once by the stimulus process
    always @(posedge aclk) begin : hold_off
        if (hold_request && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Count cycles in which neither side moves an item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("rc_pulse_input_decoder regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Queue one item and track what the block will make of it
    task automatic queue_item(logic func, logic [PW-1:0] port,
                              logic [TW-1:0] stamp, logic [2:0] rch);
        pulse_item_t it;
        it.func         = func;
        it.port         = port;
        it.capture_time = stamp;
        it.read_channel = rch;
        capture_items.push_back(it);
        if (func == rpid_pkg::FUNC_EDGE) begin
            if (cfg_ppm) begin
                gen_clock = stamp;
            end else if (port < NUM_CH) begin
                if (!gen_high[port])
                    gen_rise[port] = stamp;
                gen_high[port] = !gen_high[port];
            end
        end
    endtask

    // PPM edge a given interval after the previous one; port is don't-care
    task automatic queue_interval(logic [TW-1:0] span);
        queue_item(rpid_pkg::FUNC_EDGE, PW'($urandom), gen_clock + span, 3'($urandom));
    endtask

    task automatic queue_pwm(logic [PW-1:0] port, logic [TW-1:0] stamp);
        queue_item(rpid_pkg::FUNC_EDGE, port, stamp, 3'($urandom));
    endtask

    task automatic queue_read(logic [2:0] rch);
        queue_item(rpid_pkg::FUNC_READ, PW'($urandom), TW'($urandom), rch);
    endtask

    // Mostly a width inside the window, sometimes its edges, sometimes noise
    function automatic logic [TW-1:0] pick_span();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80 && cfg_max > cfg_min + 1)
            return TW'($urandom_range(cfg_min + 1, cfg_max - 1));
        if (roll < 90) begin
            case ($urandom_range(3))
                0: return cfg_min;
                1: return cfg_min + 16'd1;
                2: return cfg_max - 16'd1;
                default: return cfg_max;
            endcase
        end
        return TW'($urandom);
    endfunction

    task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // Write every register; only called with the block idle
    task automatic apply_config(logic ppm, logic [TW-1:0] lo, logic [TW-1:0] hi,
                                logic [TW-1:0] thresh, logic [TW-1:0] gap);
        write_reg(rpid_pkg::REG_MODE_PPM, {{(DW-1){1'b0}}, ppm});
        write_reg(rpid_pkg::REG_PULSE_MIN, lo);
        write_reg(rpid_pkg::REG_PULSE_MAX, hi);
        write_reg(rpid_pkg::REG_FS_THRESH, thresh);
        write_reg(rpid_pkg::REG_SYNC_GAP, gap);
        cfg_ppm    = ppm;
        cfg_min    = lo;
        cfg_max    = hi;
        cfg_thresh = thresh;
        cfg_gap    = gap;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Queue a random phase, then drain until every decode has been matched
    task automatic run_random(int count, int unsigned send_idle, int unsigned recv_stall,
                              bit hold);
        int unsigned roll;
        logic [PW-1:0] p;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            p    = PW'($urandom);
            if (roll < 15) begin
                queue_read(3'($urandom));
            end else if (cfg_ppm) begin
                if (frame_left == 0) begin
                    // open a frame: mostly a proper sync gap, now and then noise
                    frame_left = $urandom_range(3, 11);
                    if (roll < 90 && cfg_gap != 16'hFFFF)
                        queue_interval(TW'($urandom_range(cfg_gap + 1, 16'hFFFF)));
                    else
                        queue_interval(TW'($urandom));
                end else begin
                    frame_left--;
                    queue_interval(pick_span());
                end
            end else begin
                if (roll >= 90)
                    queue_pwm(p, TW'($urandom));
                else if (gen_high[p])
                    queue_pwm(p, gen_rise[p] + pick_span());
                else
                    queue_pwm(p, TW'($urandom));
            end
        end
        if (hold)
            hold_request = 1'b1;
        do @(negedge aclk);
        while (capture_items.size() != 0 || s_tvalid || decoded_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings, PPM: read the cleared table, then walk the window edges
        queue_read(3'd0);
        queue_interval(16'd0);          // zero interval, advances the count only
        queue_interval(16'd3000);       // sync
        queue_interval(16'd1500);       // channel 0, good
        queue_interval(16'd751);        // just above the minimum
        queue_interval(16'd2249);       // just below the maximum
        queue_interval(16'd750);        // on the minimum: dropped, count moves on
        queue_interval(16'd2250);       // on the maximum: dropped
        queue_interval(16'd2700);       // on the sync gap: not a sync
        queue_interval(16'd2701);       // sync
        queue_interval(16'd1500);
        queue_interval(16'd985);        // on the failsafe threshold: stored, not good
        queue_interval(16'd986);
        queue_interval(16'd1500);
        queue_interval(16'hFFFF);       // widest interval, timer wraps
        queue_interval(16'd1200);
        queue_interval(16'd1200);
        queue_interval(16'd1200);
        queue_interval(16'd1200);
        queue_read(3'd7);
        run_random(200, 0, 0, 1'b0);

        // PWM with reset window: wrapped width, widest width, back-to-back edges
        apply_config(1'b0, rpid_pkg::PULSE_MIN_RST, rpid_pkg::PULSE_MAX_RST,
                     rpid_pkg::FS_THRESH_RST, rpid_pkg::SYNC_GAP_RST);
        queue_pwm(3'd0, 16'd65000);
        queue_pwm(3'd0, 16'd500);
        queue_pwm(3'd7, 16'd0);
        queue_pwm(3'd7, 16'hFFFF);
        queue_pwm(3'd3, 16'd100);
        queue_pwm(3'd3, 16'd851);
        queue_read(3'd0);
        run_random(200, 0, 0, 1'b0);

        // Widest window, lowest threshold, no sync possible
        apply_config(1'b1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        run_random(120, 74, 0, 1'b0);

        // Empty window, highest threshold, every nonzero interval a sync
        apply_config(1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        run_random(80, 0, 74, 1'b0);

        apply_config(1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        run_random(200, 30, 30, 1'b0);

        // Hold the receiver off while the sender keeps offering
        apply_config(1'b1, 16'd1000, 16'd2000, 16'd1500, 16'd3000);
        run_random(200, 0, 0, 1'b1);

        apply_config(1'b0, 16'd900, 16'd2100, 16'd1200, rpid_pkg::SYNC_GAP_RST);
        run_random(200, 74, 0, 1'b0);

        apply_config(1'b1, TW'($urandom_range(500, 1000)), TW'($urandom_range(1800, 2500)),
                     TW'($urandom_range(900, 2000)), TW'($urandom_range(2400, 4000)));
        run_random(250, 0, 74, 1'b0);

        apply_config(1'b0, TW'($urandom_range(500, 1000)), TW'($urandom_range(1800, 2500)),
                     TW'($urandom_range(900, 2000)), TW'($urandom_range(2400, 4000)));
        run_random(200, 30, 30, 1'b0);

        repeat (SETTLE) @(negedge aclk);
        if (mismatch_count == 0 && decoded_results.size() == 0)
            $display("rc_pulse_input_decoder regression: pass");
        else
            $display("rc_pulse_input_decoder regression: fail");
        $finish;
    end

endmodule
